>>> rtl/assert_macros.svh
// Assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-to-next-cycle implication with reset guard
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Same-cycle implication with reset guard
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/cbmf_pkg.sv
package cbmf_pkg;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_COLS;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int DW = 16;
    localparam int SUMW = 24;   // 225 * 65535 fits in 24 bits
    localparam int NUMW = SUMW + 4;
    localparam int QW = 20;

    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
endpackage

>>> rtl/cbmf_ram.sv
module cbmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/cbmf_div.sv
// Restoring divider, one quotient bit per cycle
module cbmf_div
    import cbmf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [7:0]      den,
    output logic            done,
    output logic [QW-1:0]   quo
);
    logic [NUMW-1:0] q_reg, q_next;
    logic [8:0]      rem_reg, rem_next;
    logic [7:0]      den_reg, den_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [9:0]      trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (start)
        begin
            q_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = 5'(NUMW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, q_reg[NUMW-1]};
            q_next = {q_reg[NUMW-2:0], 1'b0};
            if (trial >= {2'b0, den_reg})
            begin
                rem_next = 9'(trial - {2'b0, den_reg});
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[8:0];
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo = q_reg[QW-1:0];
endmodule

>>> rtl/clipped_box_mean_filter_core.sv
// Clipped box mean filter core; one word in flight.
// No result: a word passes through accept, EVAL and CHECK.
// Result over n window cells (1..225): the word then walks the window, divides,
// and m_tvalid rises after OUT; the next word waits until the result is taken.
// Reset (rst_n low, async) restores rows=1024, cols=1024, radius=1 and
// restarts the frame; line store contents are left undefined.
module clipped_box_mean_filter_core
    import cbmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mean_value, out_row, out_col, zero pad
    output logic        m_tlast    // frame_end
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [12:0] rows_reg;
    logic [10:0] cols_reg;
    logic [2:0]  rad_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [AW-1:0] in_addr_reg, out_addr_reg;
    logic          full_reg;
    logic          push_reg;
    logic          drop_reg;
    logic [DW-1:0] sample_reg;

    // effective config
    logic [RW:0] er;
    logic [CW:0] ec;
    logic [2:0]  erad;
    always_comb
    begin
        er = (rows_reg == '0) ? 13'd1 : (rows_reg > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : rows_reg;
        ec = (cols_reg == '0) ? 11'd1 : (cols_reg > 11'(MAX_COLS)) ? 11'(MAX_COLS) : cols_reg;
        erad = rad_reg;
    end

    // window walk registers
    logic [RW-1:0] r1_reg, wr_reg;
    logic [CW-1:0] c0_reg, c1_reg, wc_reg;
    logic [AW-1:0] row_base_reg, rd_addr_reg;
    logic [SUMW-1:0] sum_reg;
    logic [7:0] cnt_reg;
    logic       rd_pend_reg, walk_last_reg;
    logic [DW-1:0] rdata;
    logic       last_reg;
    logic [QW-1:0] mean_reg;
    logic       mvalid_reg;

    logic div_start, div_done;
    logic [QW-1:0] quo;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(b);
        if (s >= (AW+1)'(STORE_DEPTH))
        begin
            s = s - (AW+1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [CW+3:0] b);
        logic [AW:0] s;
        s = {1'b0, a} - (AW+1)'(b);
        if (s[AW])
        begin
            s = s + (AW+1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // readiness
    logic ready_c;
    logic [RW:0] nr;
    logic [CW:0] nc;
    always_comb
    begin
        nr = (RW+1)'(out_row_reg) + (RW+1)'(erad);
        nc = (CW+1)'(out_col_reg) + (CW+1)'(erad);
        if (nr > er - 1'b1) nr = er - 1'b1;
        if (nc > ec - 1'b1) nc = ec - 1'b1;
        ready_c = full_reg || ((RW+1)'(in_row_reg) > nr) ||
                  (((RW+1)'(in_row_reg) == nr) && ((CW+1)'(in_col_reg) > nc));
    end

    cbmf_ram #(.WIDTH(DW), .DEPTH(STORE_DEPTH)) u_store (
        .clk  (clk),
        .we   (state_reg == ST_EVAL && push_reg),
        .waddr(in_addr_reg),
        .wdata(sample_reg),
        .raddr(rd_addr_reg),
        .rdata(rdata)
    );

    cbmf_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  ({sum_reg, 4'b0}),
        .den  (cnt_reg),
        .done (div_done),
        .quo  (quo)
    );

    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign div_start = (state_reg == ST_WALK) && !rd_pend_reg && walk_last_reg;
    logic in_acc;
    assign in_acc = s_tvalid && s_tready;

    // main sequencer
    logic [RW-1:0] r0_c;
    logic [CW-1:0] c0_c;
    always_comb
    begin
        r0_c = (out_row_reg >= RW'(erad)) ? out_row_reg - RW'(erad) : '0;
        c0_c = (out_col_reg >= CW'(erad)) ? out_col_reg - CW'(erad) : '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_CHECK;
            // input position is up to date: walk only when a result is due
            ST_CHECK: state_next = (ready_c && !drop_reg) ? ST_WALK : ST_IDLE;
            ST_WALK:  if (div_start) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic [RW:0] r1_c;
    logic [CW:0] c1_c;
    always_comb
    begin
        r1_c = (RW+1)'(out_row_reg) + (RW+1)'(erad);
        c1_c = (CW+1)'(out_col_reg) + (CW+1)'(erad);
        if (r1_c > er - 1'b1) r1_c = er - 1'b1;
        if (c1_c > ec - 1'b1) c1_c = ec - 1'b1;
    end

    logic [CW+3:0] back_c;
    assign back_c = (CW+4)'((out_row_reg >= RW'(erad)) ? erad : out_row_reg[2:0])
                    * (CW+4)'(ec)
                    + (CW+4)'(out_col_reg - c0_c);
    // distance back from the output address to the first window cell (r0, c0)

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rows_reg <= 13'd1024;
            cols_reg <= 11'd1024;
            rad_reg <= 3'd1;
            in_row_reg <= '0; in_col_reg <= '0;
            out_row_reg <= '0; out_col_reg <= '0;
            in_addr_reg <= '0; out_addr_reg <= '0;
            full_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            push_reg <= 1'b0;
            drop_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            walk_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mvalid_reg && m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROWS:   rows_reg <= cfg_data;
                    REG_COLS:   cols_reg <= cfg_data[10:0];
                    REG_RADIUS: rad_reg <= (cfg_data[2:0] > 3'(MAX_RADIUS)) ?
                                           3'(MAX_RADIUS) : cfg_data[2:0];
                    default: ;
                endcase
                if (cfg_index == REG_ROWS || cfg_index == REG_COLS || cfg_index == REG_RADIUS)
                begin
                    in_row_reg <= '0; in_col_reg <= '0;
                    out_row_reg <= '0; out_col_reg <= '0;
                    in_addr_reg <= '0; out_addr_reg <= '0;
                    full_reg <= 1'b0;
                end
            end
            if (in_acc)
            begin
                push_reg <= (s_tuser == CMD_PUSH) && !full_reg;
                // drop a push that arrives after a full frame, with no result
                drop_reg <= (s_tuser == CMD_PUSH) && full_reg;
            end
            if (state_reg == ST_EVAL)
            begin
                if (push_reg)
                begin
                    in_addr_reg <= wrap_add(in_addr_reg, (CW+1)'(1));
                    if ((CW+1)'(in_col_reg) + 1'b1 >= ec)
                    begin
                        in_col_reg <= '0;
                        if ((RW+1)'(in_row_reg) + 1'b1 >= er)
                        begin
                            in_row_reg <= '0;
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            in_row_reg <= in_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
            end
            if (state_reg == ST_WALK)
            begin
                if (rd_pend_reg)
                begin
                    rd_pend_reg <= 1'b0;
                    walk_last_reg <= 1'b1;
                end
                else if (!walk_last_reg)
                begin
                    rd_pend_reg <= (wr_reg == r1_reg) && (wc_reg == c1_reg);
                end
                else
                begin
                    walk_last_reg <= 1'b0;
                end
            end
            if (state_reg == ST_OUT)
            begin
                mvalid_reg <= 1'b1;
                if (last_reg)
                begin
                    in_row_reg <= '0; in_col_reg <= '0;
                    out_row_reg <= '0; out_col_reg <= '0;
                    in_addr_reg <= '0; out_addr_reg <= '0;
                    full_reg <= 1'b0;
                end
                else
                begin
                    out_addr_reg <= wrap_add(out_addr_reg, (CW+1)'(1));
                    if ((CW+1)'(out_col_reg) + 1'b1 >= ec)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Walk: issue address per cycle; accumulate the registered read data in the next cycle.
    // rd_pend marks the final issued read still in flight.
    logic acc_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= (state_reg == ST_WALK) && !walk_last_reg && !rd_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= s_tdata;
        end
        if (state_reg == ST_EVAL)
        begin
            // set up the window walk; CHECK decides whether it runs
            r1_reg <= r1_c[RW-1:0];
            c1_reg <= c1_c[CW-1:0];
            c0_reg <= c0_c;
            wr_reg <= r0_c;
            wc_reg <= c0_c;
            row_base_reg <= wrap_sub(out_addr_reg, back_c);
            rd_addr_reg <= wrap_sub(out_addr_reg, back_c);
            sum_reg <= '0;
            cnt_reg <= '0;
            last_reg <= (out_row_reg == RW'(er - 1'b1)) && (out_col_reg == CW'(ec - 1'b1));
        end
        if (state_reg == ST_WALK && !rd_pend_reg && !walk_last_reg)
        begin
            if (wc_reg == c1_reg)
            begin
                wc_reg <= c0_reg;
                wr_reg <= wr_reg + 1'b1;
                row_base_reg <= wrap_add(row_base_reg, ec);
                rd_addr_reg <= wrap_add(row_base_reg, ec);
            end
            else
            begin
                wc_reg <= wc_reg + 1'b1;
                rd_addr_reg <= wrap_add(rd_addr_reg, (CW+1)'(1));
            end
        end
        if (acc_valid_reg)
        begin
            sum_reg <= sum_reg + SUMW'(rdata);
            cnt_reg <= cnt_reg + 8'd1;
        end
        if (div_done)
        begin
            mean_reg <= quo;
        end
    end

    logic [RW-1:0] out_row_q;
    logic [CW-1:0] out_col_q;
    logic last_q;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            out_row_q <= out_row_reg;
            out_col_q <= out_col_reg;
            last_q <= last_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {6'b0, out_col_q, out_row_q, mean_reg};
    assign m_tlast = last_q;
endmodule

>>> rtl/cbmf_checker.sv
`include "assert_macros.svh"
module cbmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `ASSERT_SAME(a_pad, clk, rst_n, m_tvalid, m_tdata[47:42] == 6'b0)
    `ASSERT_NEXT(a_one, clk, rst_n, s_tvalid && s_tready, !s_tready)
endmodule

bind clipped_box_mean_filter_core cbmf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

>>> tb/tb_top.sv
module tb_top;
    import cbmf_pkg::*;

    typedef struct packed {
        logic [19:0] mean_value;
        logic [11:0] row;
        logic [9:0]  col;
        logic        frame_end;
    } mean_word_t;

    class mean_scoreboard;
        logic [15:0] line_mem [STORE_DEPTH];
        int unsigned in_r, in_c, out_r, out_c;
        int unsigned n_rows, n_cols, win_rad;
        bit          frame_full;
        mean_word_t  expected_q [$];
        int          errors;

        function void init();
            foreach (line_mem[i]) line_mem[i] = '0;
            n_rows = 1024;
            n_cols = 1024;
            win_rad = 1;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_r = 0;
            in_c = 0;
            out_r = 0;
            out_c = 0;
            frame_full = 0;
        endfunction

        function void configure(logic [1:0] idx, logic [12:0] value);
            int unsigned v;
            v = value;
            if (idx == REG_ROWS)
                n_rows = (v == 0) ? 1 : (v > MAX_ROWS ? MAX_ROWS : v);
            else if (idx == REG_COLS)
            begin
                v = v & 11'h7FF;
                n_cols = (v == 0) ? 1 : (v > MAX_COLS ? MAX_COLS : v);
            end
            else if (idx == REG_RADIUS)
            begin
                v = v & 3'h7;
                win_rad = (v > MAX_RADIUS) ? MAX_RADIUS : v;
            end
            else
                return;
            restart();
        endfunction

        function int unsigned mem_addr(int unsigned r, int unsigned c);
            longint unsigned lin;
            lin = longint'(r) * n_cols + c;
            return 32'(lin % STORE_DEPTH);
        endfunction

        function bit window_ready();
            int unsigned nr, nc;
            if (frame_full) return 1;
            nr = out_r + win_rad;
            nc = out_c + win_rad;
            if (nr > n_rows - 1) nr = n_rows - 1;
            if (nc > n_cols - 1) nc = n_cols - 1;
            return (in_r > nr) || (in_r == nr && in_c > nc);
        endfunction

        function void predict_mean();
            int unsigned r0, c0, r1, c1;
            longint unsigned sum, cnt;
            mean_word_t w;
            if (!window_ready()) return;
            r0 = (out_r >= win_rad) ? out_r - win_rad : 0;
            c0 = (out_c >= win_rad) ? out_c - win_rad : 0;
            r1 = out_r + win_rad;
            c1 = out_c + win_rad;
            if (r1 > n_rows - 1) r1 = n_rows - 1;
            if (c1 > n_cols - 1) c1 = n_cols - 1;
            sum = 0;
            cnt = 0;
            for (int unsigned i = r0; i <= r1; i++)
                for (int unsigned j = c0; j <= c1; j++)
                begin
                    sum += line_mem[mem_addr(i, j)];
                    cnt++;
                end
            w.mean_value = 20'((sum * 16) / cnt);
            w.row = 12'(out_r);
            w.col = 10'(out_c);
            w.frame_end = (out_r == n_rows - 1) && (out_c == n_cols - 1);
            expected_q.push_back(w);
            if (w.frame_end)
                restart();
            else
            begin
                out_c++;
                if (out_c >= n_cols)
                begin
                    out_c = 0;
                    out_r++;
                end
            end
        endfunction

        function void note_input(logic cmd, logic [15:0] sample);
            if (cmd == CMD_PUSH)
            begin
                if (frame_full) return;
                line_mem[mem_addr(in_r, in_c)] = sample;
                in_c++;
                if (in_c >= n_cols)
                begin
                    in_c = 0;
                    in_r++;
                    if (in_r >= n_rows)
                    begin
                        in_r = 0;
                        frame_full = 1;
                    end
                end
            end
            predict_mean();
        endfunction

        function void check_result(logic [47:0] data, logic last);
            mean_word_t w;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: %h last %b", data, last);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (data[19:0] !== w.mean_value)
            begin
                $error("mean_value: expected %0d actual %0d", w.mean_value, data[19:0]);
                errors++;
            end
            if (data[31:20] !== w.row)
            begin
                $error("out_row: expected %0d actual %0d", w.row, data[31:20]);
                errors++;
            end
            if (data[41:32] !== w.col)
            begin
                $error("out_col: expected %0d actual %0d", w.col, data[41:32]);
                errors++;
            end
            if (data[47:42] !== 6'd0)
            begin
                $error("pad: expected 0 actual %0d", data[47:42]);
                errors++;
            end
            if (last !== w.frame_end)
            begin
                $error("frame_end: expected %0d actual %0d", w.frame_end, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 320;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    mean_scoreboard sb;
    int  items_sent;
    int  burst_left;
    int  idle_cycles;
    int  stall_mode;
    int  mode_left;

    clipped_box_mean_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Receiver: check accepted words, stall on a pattern that changes mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(64, 400);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic write_regs(int unsigned r, int unsigned c, int unsigned rad);
        logic [1:0]  idx [3];
        logic [12:0] val [3];
        idx[0] = REG_ROWS;
        idx[1] = REG_COLS;
        idx[2] = REG_RADIUS;
        val[0] = 13'(r);
        val[1] = 13'(c);
        val[2] = 13'(rad);
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            sb.configure(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic cmd, logic [15:0] sample);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= sample;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(cmd, sample);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame setting: fill the frame and flush out the rest, or send only part of it
    task automatic run_frame(int unsigned r, int unsigned c, int unsigned rad,
                             bit complete, int count, int flush_pct);
        int extra;
        write_regs(r, c, rad);
        extra = 0;
        if (complete)
        begin
            while (!sb.frame_full)
            begin
                if ($urandom_range(0, 99) < flush_pct)
                    send_word(CMD_FLUSH, rand_sample());
                else
                    send_word(CMD_PUSH, rand_sample());
                if (sb.in_r == 0 && sb.in_c == 0 && !sb.frame_full)
                    break;
            end
            while (sb.frame_full)
            begin
                if (extra < 2 && $urandom_range(0, 4) == 0)
                begin
                    send_word(CMD_PUSH, rand_sample());
                    extra++;
                end
                else
                    send_word(CMD_FLUSH, rand_sample());
            end
            // flush with nothing pending
            if ($urandom_range(0, 3) == 0)
                send_word(CMD_FLUSH, rand_sample());
        end
        else
            for (int i = 0; i < count; i++)
                send_word(($urandom_range(0, 99) < flush_pct) ? CMD_FLUSH : CMD_PUSH,
                          rand_sample());
        drain_and_settle();
    endtask

    initial
    begin
        int unsigned r, c, rad;
        int sel;
        sb = new();
        sb.init();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        items_sent = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: too few rows pushed for any result
        send_word(CMD_PUSH, 16'hFFFF);
        send_word(CMD_FLUSH, 16'h0000);
        send_word(CMD_PUSH, 16'h0000);
        drain_and_settle();

        // Single-cell raster, zero radius; then zero sizes acting as one
        run_frame(1, 1, 0, 1, 0, 0);
        run_frame(0, 0, 7, 1, 0, 0);
        // Rows above the maximum, one column, widest window
        run_frame(8191, 1, 7, 0, 10, 0);
        // Columns above the maximum, one row
        run_frame(1, 2047, 0, 0, 4, 0);
        // Small frame with the window wider than the raster
        run_frame(2, 3, 7, 1, 0, 20);

        while (items_sent < 870)
        begin
            sel = $urandom_range(0, 19);
            rad = $urandom_range(0, 7);
            if (sel == 0)
                run_frame(4096, 1, rad, 0, $urandom_range(5, 20), 10);
            else if (sel == 1)
                run_frame(1, 1024, $urandom_range(0, 3), 0, $urandom_range(5, 20), 10);
            else if (sel < 4)
            begin
                r = $urandom_range(2, 3);
                c = $urandom_range(16, 40);
                run_frame(r, c, rad, 1, 0, 5);
            end
            else
            begin
                r = $urandom_range(1, 6);
                c = $urandom_range(1, 8);
                if (sel < 7)
                    run_frame(r, c, rad, 0, $urandom_range(1, r * c), 15);
                else
                    run_frame(r, c, rad, 1, 0, 10);
            end
        end

        drain_and_settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
